[rtl/text_console_cursor_scroll_top_macros.svh]
// Assertion macros for the console block.
// ASSERT_RST: clocked property, disabled while reset is asserted (active low).
// ASSERT_CLK: clocked property, always checked.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)
`endif
`endif

[rtl/tccs_pkg.sv]
`default_nettype none
package tccs_pkg;

    localparam int ROWS_DEF    = 30;
    localparam int COLS_DEF    = 80;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] GLYPH_MARK  = 8'h5F;
    localparam logic [7:0] GLYPH_BLANK = 8'h20;
    localparam logic [7:0] CODE_CR     = 8'h0D;
    localparam logic [7:0] CODE_LF     = 8'h0A;
    localparam logic [7:0] CODE_VIS_LO = 8'h20;
    localparam logic [7:0] CODE_VIS_HI = 8'h7F;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK  = 3'd4;

    typedef enum logic [1:0] {
        OP_MARK,
        OP_PRINT,
        OP_CR,
        OP_LF
    } t_op_kind;

    typedef enum logic [1:0] {
        ST_FIRST,
        ST_FILL,
        ST_MARK
    } t_step;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] code;
    } t_op;

    typedef struct packed {
        logic push;
        t_op  op;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_rd;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
    } t_in_beat;

    typedef struct packed {
        logic        entry_kind;
        logic [11:0] vram_index;
        logic [7:0]  glyph_code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        inverted;
        logic        blinking;
        logic [4:0]  row_offset;
        logic        last;
    } t_out_beat;

endpackage
`default_nettype wire

[rtl/tccs_front.sv]
`default_nettype none
module tccs_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  tccs_pkg::t_in_beat  i_in_beat,
    output logic                o_in_stall,
    input  wire                 i_q_full,
    output tccs_pkg::t_q_wr     o_wr
);
    import tccs_pkg::*;

    logic     w_take;
    logic     w_keep;
    t_op_kind w_kind;

    assign o_in_stall = i_q_full;
    assign w_take     = i_in_valid && !i_q_full;

    // non-func codes other than visible ones, CR and LF are dropped here
    always_comb begin
        w_keep = 1'b1;
        w_kind = OP_MARK;
        if (i_in_beat.func) begin
            w_kind = OP_MARK;
        end else if (i_in_beat.char_code inside {[CODE_VIS_LO:CODE_VIS_HI]}) begin
            w_kind = OP_PRINT;
        end else if (i_in_beat.char_code == CODE_CR) begin
            w_kind = OP_CR;
        end else if (i_in_beat.char_code == CODE_LF) begin
            w_kind = OP_LF;
        end else begin
            w_keep = 1'b0;
        end
    end

    assign o_wr.push    = w_take && w_keep;
    assign o_wr.op.kind = w_kind;
    assign o_wr.op.code = i_in_beat.char_code;

    `include "text_console_cursor_scroll_top_macros.svh"
    `ASSERT_RST(a_no_push_when_full, i_clk, i_rst_n, i_q_full |-> !o_wr.push)
    `ASSERT_RST(a_mark_always_kept, i_clk, i_rst_n, (w_take && i_in_beat.func) |-> o_wr.push)
    `ASSERT_RST(a_high_codes_dropped, i_clk, i_rst_n,
                (i_in_beat.char_code[7] && !i_in_beat.func) |-> !o_wr.push)

endmodule
`default_nettype wire

[rtl/tccs_queue.sv]
`default_nettype none
module tccs_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  tccs_pkg::t_q_wr  i_wr,
    output logic             o_full,
    output tccs_pkg::t_q_rd  o_rd,
    input  wire              i_pop
);
    import tccs_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QPTR_W:0]   n_count;
    logic              w_pop;

    assign o_full   = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.op  = r_mem[r_rptr];
    assign w_pop    = i_pop && o_rd.valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_wr.push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        if (i_wr.push && !w_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (!i_wr.push && w_pop) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wptr] <= i_wr.op;
        end
    end

    `include "text_console_cursor_scroll_top_macros.svh"
    `ASSERT_RST(a_count_range, i_clk, i_rst_n, r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
    `ASSERT_RST(a_ptr_gap, i_clk, i_rst_n, (r_count == '0 || o_full) |-> (r_wptr == r_rptr))
    `ASSERT_RST(a_no_overflow, i_clk, i_rst_n, o_full |-> !i_wr.push)

endmodule
`default_nettype wire

[rtl/tccs_back.sv]
`default_nettype none
module tccs_back #(
    parameter int ROWS = tccs_pkg::ROWS_DEF,
    parameter int COLS = tccs_pkg::COLS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [tccs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [tccs_pkg::CFG_W-1:0]        i_cfg_data,
    input  tccs_pkg::t_q_rd                  i_rd,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output tccs_pkg::t_out_beat              o_out_beat
);
    import tccs_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int IDX_W = $clog2(ROWS * COLS);

    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic             r_invert;
    logic             r_blink;

    t_step            r_state;
    t_step            n_state;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_offset;
    logic [ROW_W-1:0] n_offset;
    logic [ROW_W-1:0] r_phys;      // physical row of the cursor
    logic [ROW_W-1:0] n_phys;
    logic             r_out_valid;
    t_out_beat        r_out;
    t_out_beat        w_res;

    logic             w_load;
    logic             w_last_col;
    logic             w_last_row;
    logic             w_adv;
    logic             w_fill;
    logic [ROW_W-1:0] w_mrow;
    logic [COL_W-1:0] w_mcol;
    logic [IDX_W-1:0] w_idx;

    assign w_load = (!r_out_valid || !i_out_stall) && ((r_state != ST_FIRST) || i_rd.valid);
    assign w_last_col = (r_col == COL_W'(COLS-1));
    assign w_last_row = (r_row == ROW_W'(ROWS-1));
    // move down a row: LF, or a printed char in the last column
    assign w_adv = (i_rd.op.kind == OP_LF) || ((i_rd.op.kind == OP_PRINT) && w_last_col);

    // next step of the sequencer
    always_comb begin
        n_state = r_state;
        if (w_load) begin
            case (r_state)
                ST_FIRST: begin
                    if (i_rd.op.kind == OP_MARK) begin
                        n_state = ST_FIRST;
                    end else if (w_adv && w_last_row) begin
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_MARK;
                    end
                end
                ST_FILL:  n_state = ST_MARK;
                ST_MARK:  n_state = ST_FIRST;
                default:  n_state = ST_FIRST;
            endcase
        end
    end

    // result word and cursor updates
    assign w_fill = (r_state == ST_FILL);
    assign w_mrow = w_fill ? r_offset : r_phys;
    assign w_mcol = w_fill ? '0 : r_col;
    assign w_idx  = IDX_W'(w_mrow * COLS) + IDX_W'(w_mcol);

    always_comb begin
        w_res.entry_kind = w_fill;
        w_res.vram_index = 12'(w_idx);
        w_res.glyph_code = GLYPH_MARK;
        w_res.red        = r_red;
        w_res.green      = r_green;
        w_res.blue       = r_blue;
        w_res.inverted   = 1'b0;
        w_res.blinking   = 1'b1;
        w_res.row_offset = 5'(r_offset);
        w_res.last       = 1'b0;
        o_pop            = 1'b0;
        n_row            = r_row;
        n_col            = r_col;
        n_offset         = r_offset;
        n_phys           = r_phys;
        case (r_state)
            ST_FIRST: begin
                case (i_rd.op.kind)
                    OP_MARK: begin
                        w_res.last = 1'b1;
                        o_pop      = w_load;
                    end
                    OP_PRINT: begin
                        w_res.glyph_code = i_rd.op.code;
                        w_res.inverted   = r_invert;
                        w_res.blinking   = r_blink;
                    end
                    default: begin
                        w_res.glyph_code = GLYPH_BLANK;
                        w_res.blinking   = 1'b0;
                    end
                endcase
                if (i_rd.op.kind == OP_CR || (i_rd.op.kind == OP_PRINT && w_last_col)) begin
                    n_col = '0;
                end else if (i_rd.op.kind == OP_PRINT) begin
                    n_col = r_col + COL_W'(1);
                end
                if (w_adv && !w_last_row) begin
                    n_row  = r_row + ROW_W'(1);
                    n_phys = (r_phys == ROW_W'(ROWS-1)) ? '0 : r_phys + ROW_W'(1);
                end
            end
            ST_FILL: begin
                // blank the top physical row, then scroll by one
                w_res.glyph_code = GLYPH_BLANK;
                w_res.blinking   = 1'b0;
                n_offset = (r_offset == ROW_W'(ROWS-1)) ? '0 : r_offset + ROW_W'(1);
                n_phys   = r_offset;
            end
            ST_MARK: begin
                w_res.last = 1'b1;
                o_pop      = w_load;
            end
            default: begin
                w_res.last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FIRST;
            r_row       <= '0;
            r_col       <= '0;
            r_offset    <= '0;
            r_phys      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_row    <= n_row;
                r_col    <= n_col;
                r_offset <= n_offset;
                r_phys   <= n_phys;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red    <= 8'hFF;
            r_green  <= 8'hFF;
            r_blue   <= 8'hFF;
            r_invert <= 1'b0;
            r_blink  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RED:    r_red    <= i_cfg_data[7:0];
                CFG_GREEN:  r_green  <= i_cfg_data[7:0];
                CFG_BLUE:   r_blue   <= i_cfg_data[7:0];
                CFG_INVERT: r_invert <= i_cfg_data[0];
                CFG_BLINK:  r_blink  <= i_cfg_data[0];
                default:    r_red    <= r_red;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `include "text_console_cursor_scroll_top_macros.svh"
    `ASSERT_RST(a_offset_range, i_clk, i_rst_n, int'(r_offset) < ROWS)
    `ASSERT_RST(a_col_range, i_clk, i_rst_n, int'(r_col) < COLS)
    `ASSERT_RST(a_phys_consistent, i_clk, i_rst_n, (int'(r_offset) + int'(r_row) == int'(r_phys)) || (int'(r_offset) + int'(r_row) == int'(r_phys) + ROWS))
    `ASSERT_RST(a_fill_on_last_row, i_clk, i_rst_n, (r_state == ST_FILL) |-> (int'(r_row) == ROWS - 1))
    `ASSERT_RST(a_fill_not_last, i_clk, i_rst_n, (r_out_valid && r_out.entry_kind) |-> !r_out.last)

endmodule
`default_nettype wire

[rtl/text_console_cursor_scroll_top.sv]
`default_nettype none
// Character console controller. Each input beat either prints a byte or (func = 1) writes
// the cursor mark; it produces one to three text-memory write beats, one per clock while
// the output is not stalled, the last of them flagged. A printable byte gives a char write
// plus a cursor mark, CR and LF blank the old mark and write a new one, and an LF or wrap
// on the bottom row adds a whole-row blank fill and scrolls the display offset. Other
// bytes give nothing. Input beats land in a four-entry op queue, so the input side takes
// one beat per clock until it fills; the output sequencer pops each op with its last write
// beat, which sets the sustained rate. Ignored bytes cost no sequencer time. The output is
// registered. Configuration writes take effect the next clock and are meant for idle time.
module text_console_cursor_scroll_top #(
    parameter int ROWS = tccs_pkg::ROWS_DEF,
    parameter int COLS = tccs_pkg::COLS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  tccs_pkg::t_in_beat             i_in_beat,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output tccs_pkg::t_out_beat            o_out_beat,
    input  wire                            i_cfg_we,
    input  wire [tccs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [tccs_pkg::CFG_W-1:0]      i_cfg_data
);
    import tccs_pkg::*;

    t_q_wr w_wr;
    t_q_rd w_rd;
    logic  w_full;
    logic  w_pop;

    tccs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_full),
        .o_wr       (w_wr)
    );

    tccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_full  (w_full),
        .o_rd    (w_rd),
        .i_pop   (w_pop)
    );

    tccs_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rd        (w_rd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
`default_nettype wire

[verif/text_console_cursor_scroll_checker.sv]
module text_console_cursor_scroll_checker #(
    parameter int ROWS = tccs_pkg::ROWS_DEF,
    parameter int COLS = tccs_pkg::COLS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    input  wire                           i_in_stall,
    input  tccs_pkg::t_in_beat            i_in_beat,
    input  wire                           i_out_valid,
    input  wire                           i_out_stall,
    input  tccs_pkg::t_out_beat           i_out_beat,
    input  wire                           i_cfg_we,
    input  wire [tccs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [tccs_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_pending,
    output int                            o_mismatches
);
    import tccs_pkg::*;

    // palette and attributes as last written
    logic [7:0] red_q, green_q, blue_q;
    logic       invert_q, blink_q;

    // cursor and scroll position
    logic [4:0] row_q;
    logic [6:0] col_q;
    logic [4:0] offset_q;

    t_out_beat  vram_writes_due[$];
    int         mismatches = 0;

    function automatic logic [11:0] entry_addr(input logic [4:0] row, input logic [6:0] col);
        int r;
        r = int'(offset_q) + int'(row);
        if (r >= ROWS) r -= ROWS;
        return 12'(r * COLS + int'(col));
    endfunction

    function automatic t_out_beat make_write(input logic kind, input logic [11:0] addr,
                                             input logic [7:0] glyph, input logic inv,
                                             input logic blk);
        t_out_beat w;
        w.entry_kind = kind;
        w.vram_index = addr;
        w.glyph_code = glyph;
        w.red        = red_q;
        w.green      = green_q;
        w.blue       = blue_q;
        w.inverted   = inv;
        w.blinking   = blk;
        w.row_offset = offset_q;
        w.last       = 1'b0;
        return w;
    endfunction

    task automatic push_cursor_mark();
        vram_writes_due.push_back(make_write(1'b0, entry_addr(row_q, col_q), GLYPH_MARK,
                                             1'b0, 1'b1));
    endtask

    // move down a row; on the bottom row blank the top physical row and scroll
    task automatic advance_row();
        if (int'(row_q) < ROWS - 1) begin
            row_q = row_q + 5'd1;
        end else begin
            vram_writes_due.push_back(make_write(1'b1, entry_addr(5'd0, 7'd0), GLYPH_BLANK,
                                                 1'b0, 1'b0));
            offset_q = (int'(offset_q) == ROWS - 1) ? 5'd0 : offset_q + 5'd1;
        end
        push_cursor_mark();
    endtask

    task automatic predict_console_writes(input t_in_beat b);
        int        due_at_entry;
        t_out_beat tail;
        due_at_entry = vram_writes_due.size();
        if (b.func) begin
            push_cursor_mark();
        end else if (b.char_code >= CODE_VIS_LO && b.char_code <= CODE_VIS_HI) begin
            vram_writes_due.push_back(make_write(1'b0, entry_addr(row_q, col_q), b.char_code,
                                                 invert_q, blink_q));
            if (int'(col_q) < COLS - 1) begin
                col_q = col_q + 7'd1;
                push_cursor_mark();
            end else begin
                col_q = 7'd0;
                advance_row();
            end
        end else if (b.char_code == CODE_CR) begin
            vram_writes_due.push_back(make_write(1'b0, entry_addr(row_q, col_q), GLYPH_BLANK,
                                                 1'b0, 1'b0));
            col_q = 7'd0;
            push_cursor_mark();
        end else if (b.char_code == CODE_LF) begin
            vram_writes_due.push_back(make_write(1'b0, entry_addr(row_q, col_q), GLYPH_BLANK,
                                                 1'b0, 1'b0));
            advance_row();
        end
        if (vram_writes_due.size() > due_at_entry) begin
            tail = vram_writes_due.pop_back();
            tail.last = 1'b1;
            vram_writes_due.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_write(input t_out_beat want, input t_out_beat got);
        check_field("entry_kind", 32'(want.entry_kind), 32'(got.entry_kind));
        check_field("vram_index", 32'(want.vram_index), 32'(got.vram_index));
        check_field("glyph_code", 32'(want.glyph_code), 32'(got.glyph_code));
        check_field("red",        32'(want.red),        32'(got.red));
        check_field("green",      32'(want.green),      32'(got.green));
        check_field("blue",       32'(want.blue),       32'(got.blue));
        check_field("inverted",   32'(want.inverted),   32'(got.inverted));
        check_field("blinking",   32'(want.blinking),   32'(got.blinking));
        check_field("row_offset", 32'(want.row_offset), 32'(got.row_offset));
        check_field("last",       32'(want.last),       32'(got.last));
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            red_q    = 8'd255;
            green_q  = 8'd255;
            blue_q   = 8'd255;
            invert_q = 1'b0;
            blink_q  = 1'b0;
            row_q    = 5'd0;
            col_q    = 7'd0;
            offset_q = 5'd0;
            vram_writes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RED:    red_q    = i_cfg_data;
                    CFG_GREEN:  green_q  = i_cfg_data;
                    CFG_BLUE:   blue_q   = i_cfg_data;
                    CFG_INVERT: invert_q = i_cfg_data[0];
                    CFG_BLINK:  blink_q  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (vram_writes_due.size() == 0) begin
                    $error("write beat with none expected: index %0d glyph %0h",
                           i_out_beat.vram_index, i_out_beat.glyph_code);
                    mismatches++;
                end else begin
                    want = vram_writes_due.pop_front();
                    compare_write(want, i_out_beat);
                end
            end
            if (i_in_valid && !i_in_stall) predict_console_writes(i_in_beat);
        end
        o_pending    <= vram_writes_due.size();
        o_mismatches <= mismatches;
    end

endmodule

[verif/text_console_cursor_scroll_top_tb.sv]
module text_console_cursor_scroll_top_tb;
    import tccs_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 38;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    wire                  in_stall;
    t_in_beat             in_beat;
    wire                  out_valid;
    logic                 out_stall;
    t_out_beat            out_beat;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int pending;
    int mismatches;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    text_console_cursor_scroll_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    text_console_cursor_scroll_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= (receiver_stall_pct != 0) && ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("text_console_cursor_scroll_top_tb: errors");
        $finish;
    end

    // valid stays high between back-to-back beats; it only drops for a gap
    task automatic send_char(input logic f, input logic [7:0] c);
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do begin
                in_beat <= t_in_beat'(9'($urandom));
                @(posedge clk);
            end while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_beat  <= '{func: f, char_code: c};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_writes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // ignored bytes leave no trace in the expected queue, so give them time to pass
    task automatic load_palette(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                                input logic [7:0] inv, input logic [7:0] blk);
        logic [CFG_IDX_W-1:0] regs [5];
        logic [CFG_W-1:0]     vals [5];
        regs = '{CFG_RED, CFG_GREEN, CFG_BLUE, CFG_INVERT, CFG_BLINK};
        vals = '{r, g, b, inv, blk};
        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        for (int k = 0; k < 5; k++) begin
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] visible_code();
        return 8'($urandom_range(CODE_VIS_LO, CODE_VIS_HI));
    endfunction

    function automatic logic [7:0] stray_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CODE_VIS_LO && c <= CODE_VIS_HI) || c == CODE_CR || c == CODE_LF);
        return c;
    endfunction

    // burst length, cut to what is left of the session
    function automatic int room(input int want, input int left);
        return (want < left) ? want : left;
    endfunction

    task automatic send_text(input int len);
        for (int k = 0; k < len; k++) send_char(1'b0, visible_code());
    endtask

    // line-oriented traffic: text runs, line feeds to reach the bottom row and scroll,
    // the odd full line to wrap, with some stray bytes mixed in
    task automatic console_session(input int items);
        int         sent;
        int         pick;
        int         len;
        logic [7:0] c;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 19) == 0) drain_writes();
            pick = $urandom_range(0, 19);
            if (pick <= 5) begin
                len = room($urandom_range(1, 6), items - sent);
                for (int k = 0; k < len; k++) send_char(1'b0, CODE_LF);
                sent += len;
            end else if (pick <= 11) begin
                len = room($urandom_range(1, 14), items - sent);
                send_text(len);
                sent += len;
            end else if (pick <= 13) begin
                len = room($urandom_range(0, 10), items - sent - 1);
                send_char(1'b0, CODE_CR);
                send_text(len);
                sent += len + 1;
            end else if (pick == 14) begin
                send_char(1'b1, 8'($urandom));
                sent++;
            end else if (pick <= 16) begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) send_char(1'b0, stray_code());
            end else if (pick == 17) begin
                len = room($urandom_range(75, 85), items - sent);
                send_text(len);
                sent += len;
            end else if (pick == 18) begin
                send_char(1'b0, CODE_CR);
                send_char(1'b0, CODE_LF);
                sent += 2;
            end else begin
                c = 8'($urandom);
                send_char(1'b0, c);
                if ((c >= CODE_VIS_LO && c <= CODE_VIS_HI) || c == CODE_CR || c == CODE_LF)
                    sent++;
            end
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_beat   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct    = 15;
        receiver_stall_pct = 65;

        // directed: start-up mark, field extremes, CR/LF, ignored bytes, reset palette
        send_char(1'b1, 8'h00);
        send_char(1'b1, 8'hFF);
        send_char(1'b0, CODE_VIS_LO);
        send_char(1'b0, CODE_VIS_HI);
        send_char(1'b0, 8'h41);
        send_char(1'b0, CODE_CR);
        send_char(1'b0, CODE_LF);
        send_char(1'b0, 8'h00);
        send_char(1'b0, 8'h1F);
        send_char(1'b0, 8'h80);
        send_char(1'b0, 8'hFF);
        send_char(1'b0, 8'h0B);
        send_char(1'b0, 8'h0C);
        send_char(1'b0, 8'h0E);
        drain_writes();
        send_char(1'b0, 8'h7E);
        send_char(1'b0, CODE_CR);
        send_char(1'b0, CODE_CR);
        send_char(1'b0, CODE_LF);
        send_char(1'b1, CODE_CR);

        load_palette(8'h00, 8'hFF, 8'hA5, 8'h01, 8'h00);
        send_char(1'b0, 8'h5A);
        send_char(1'b0, CODE_LF);
        send_char(1'b0, 8'h20);

        // walk down to the bottom row so later line feeds and wraps scroll
        repeat (ROWS_DEF) send_char(1'b0, CODE_LF);

        load_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        console_session(PHASE_ITEMS);

        sender_idle_pct    = 65;
        receiver_stall_pct = 15;
        load_palette(8'hFF, 8'h00, 8'hFF, 8'hFE, 8'h01);
        console_session(PHASE_ITEMS);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        load_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'hFF, 8'hFF);
        console_session(PHASE_ITEMS);

        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("text_console_cursor_scroll_top_tb: clean");
        end else begin
            $display("text_console_cursor_scroll_top_tb: errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tccs_pkg.sv
rtl/tccs_front.sv
rtl/tccs_queue.sv
rtl/tccs_back.sv
rtl/text_console_cursor_scroll_top.sv
verif/text_console_cursor_scroll_checker.sv
verif/text_console_cursor_scroll_top_tb.sv
